FILE: rtl/falling_sand_grid_step_unit_assert.svh
// assertion macros for the falling sand grid step unit
// included by files that carry concurrent assertions, no other dependencies
`ifndef FALLING_SAND_GRID_STEP_UNIT_ASSERT_SVH
`define FALLING_SAND_GRID_STEP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define FSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define FSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define FSG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FSG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/fsg_pkg.sv
// shared types, codes and sizing constants of the falling sand grid step unit
// no dependencies
package fsg_pkg;

    // grid maxima
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    // derived sizes
    localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
    localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int XY_W   = (X_W > Y_W) ? X_W : Y_W;
    localparam int CMP_W  = ((XY_W + 1) > 8) ? (XY_W + 1) : 9;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int COORD_W  = 7;
    localparam int COLOUR_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_VAL_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    // reset values of the registers
    localparam logic [CFG_VAL_W-1:0] GRID_WIDTH_RST  = 8'd128;
    localparam logic [CFG_VAL_W-1:0] GRID_HEIGHT_RST = 8'd128;

    // neighbour direction codes
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_HERE  = 2'd0;
    localparam t_dir DIR_BELOW = 2'd1;
    localparam t_dir DIR_RIGHT = 2'd2;
    localparam t_dir DIR_LEFT  = 2'd3;

    // one stored cell
    typedef struct packed {
        logic                occ;
        logic                wall;
        logic [COLOUR_W-1:0] colour;
    } t_cell;

    // request beat payload
    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [COORD_W-1:0]  cell_x;
        logic [COORD_W-1:0]  cell_y;
        logic                wr_occupied;
        logic                wr_wall;
        logic [COLOUR_W-1:0] wr_colour;
    } t_req;

    // result beat payload
    typedef struct packed {
        logic [REQ_W-1:0]    req_echo;
        logic                rd_occupied;
        logic                rd_wall;
        logic [COLOUR_W-1:0] rd_colour;
        logic                coord_error;
    } t_res;

    // configuration beat payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_VAL_W-1:0] value;
    } t_cfg;

    // neighbour unit result
    typedef struct packed {
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } t_nbr;

    // column-major cell address
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(x) * ADDR_W'(MAX_HEIGHT);
        return prod + ADDR_W'(y);
    endfunction

endpackage

FILE: rtl/fsg_req_if.sv
// request channel of the falling sand grid step unit
// depends on fsg_pkg
interface fsg_req_if;
    import fsg_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fsg_res_if.sv
// result channel of the falling sand grid step unit
// depends on fsg_pkg
interface fsg_res_if;
    import fsg_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fsg_cfg_if.sv
// configuration write channel of the falling sand grid step unit
// depends on fsg_pkg
interface fsg_cfg_if;
    import fsg_pkg::*;

    logic valid;
    logic ready;
    t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fsg_cell_mem.sv
// cell store: one write port, one read port with registered read data
// depends on fsg_pkg
module fsg_cell_mem (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [fsg_pkg::ADDR_W-1:0] i_waddr,
    input  fsg_pkg::t_cell        i_wdata,
    input  logic [fsg_pkg::ADDR_W-1:0] i_raddr,
    output fsg_pkg::t_cell        o_rdata
);
    import fsg_pkg::*;

    t_cell r_mem [CELLS];
    t_cell r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/fsg_nbr_unit.sv
// shared neighbour unit: offsets a coordinate, checks it against the grid, forms the address
// depends on fsg_pkg
module fsg_nbr_unit (
    input  logic [fsg_pkg::CMP_W-1:0] i_x,
    input  logic [fsg_pkg::CMP_W-1:0] i_y,
    input  fsg_pkg::t_dir             i_dir,
    input  logic [fsg_pkg::CMP_W-1:0] i_w,
    input  logic [fsg_pkg::CMP_W-1:0] i_h,
    output fsg_pkg::t_nbr             o_nbr
);
    import fsg_pkg::*;

    logic [CMP_W-1:0] nx;
    logic [CMP_W-1:0] ny;

    // one offset per direction, none for here
    always_comb begin
        nx = i_x;
        ny = i_y;
        unique case (i_dir)
            DIR_HERE: begin
                nx = i_x;
                ny = i_y;
            end
            DIR_BELOW: begin
                ny = i_y + CMP_W'(1);
            end
            DIR_RIGHT: begin
                nx = i_x + CMP_W'(1);
            end
            DIR_LEFT: begin
                nx = i_x - CMP_W'(1);
            end
        endcase
    end

    // range check and address
    assign o_nbr.in_range = (nx < i_w) && (ny < i_h);
    assign o_nbr.addr     = cell_addr(nx[X_W-1:0], ny[Y_W-1:0]);
endmodule

FILE: rtl/falling_sand_grid_step_unit.sv
// write request: from accept through S_FIN to the result register; read request: through S_RDATA
// and S_FIN; S_FIN loads the result register once the output is free, then S_IDLE takes the next request
// step request: visits (W-1)*(H-1) cells, each through S_HERE_RD, S_HERE_CHK, the S_TRY/S_NBR_CHK probes,
// S_WR_SRC on a move and S_NEXT; the cell and its neighbour probes share the single read port of the cell store
// reset is synchronous; afterwards a sweep over all 16384 cells empties every cell, no request taken
// configuration writes are taken in every cycle
`include "falling_sand_grid_step_unit_assert.svh"

module falling_sand_grid_step_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fsg_req_if.sink   i_req,
    fsg_res_if.source o_res,
    fsg_cfg_if.sink   i_cfg
);
    import fsg_pkg::*;

    // sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RDATA    = 4'd2;
    localparam logic [3:0] S_HERE_RD  = 4'd3;
    localparam logic [3:0] S_HERE_CHK = 4'd4;
    localparam logic [3:0] S_TRY      = 4'd5;
    localparam logic [3:0] S_NBR_CHK  = 4'd6;
    localparam logic [3:0] S_WR_SRC   = 4'd7;
    localparam logic [3:0] S_NEXT     = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]           r_state;
    logic [ADDR_W-1:0]    r_clr_addr;
    logic [CFG_VAL_W-1:0] r_grid_width;
    logic [CFG_VAL_W-1:0] r_grid_height;
    logic [X_W-1:0]       r_x;
    logic [Y_W-1:0]       r_y;
    t_dir                 r_dir;
    logic                 r_odd;
    logic [COLOUR_W-1:0]  r_col;
    logic [REQ_W-1:0]     r_req;
    logic                 r_err;
    logic                 r_rd_occ;
    logic                 r_rd_wall;
    logic [COLOUR_W-1:0]  r_rd_col;
    t_res                 r_out;
    logic                 r_out_valid;

    logic [CMP_W-1:0] eff_w;
    logic [CMP_W-1:0] eff_h;
    logic [CMP_W-1:0] gw;
    logic [CMP_W-1:0] gh;
    logic [CMP_W-1:0] u_x;
    logic [CMP_W-1:0] u_y;
    t_dir             u_dir;
    t_nbr             nbr;
    t_cell            rdata;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_cell            mem_wdata;
    logic             req_acc;
    logic             is_rw;
    logic             out_free;
    logic             try_ok;
    t_dir             dir_next;

    // effective grid size, saturated to the maxima
    assign gw    = CMP_W'(r_grid_width);
    assign gh    = CMP_W'(r_grid_height);
    assign eff_w = (gw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : gw;
    assign eff_h = (gh > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : gh;

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    assign out_free    = !r_out_valid || o_res.ready;
    assign is_rw       = (i_req.data.req_type == REQ_WRITE) ||
                         (i_req.data.req_type == REQ_READ);

    // neighbour unit operands
    always_comb begin
        if (r_state == S_IDLE) begin
            u_x   = CMP_W'(i_req.data.cell_x);
            u_y   = CMP_W'(i_req.data.cell_y);
            u_dir = DIR_HERE;
        end else begin
            u_x   = CMP_W'(r_x);
            u_y   = CMP_W'(r_y);
            u_dir = ((r_state == S_HERE_RD) || (r_state == S_WR_SRC)) ? DIR_HERE : r_dir;
        end
    end

    fsg_nbr_unit u_nbr (
        .i_x   (u_x),
        .i_y   (u_y),
        .i_dir (u_dir),
        .i_w   (eff_w),
        .i_h   (eff_h),
        .o_nbr (nbr)
    );

    // probe order: below, right on odd count, then left
    assign try_ok = nbr.in_range && ((r_dir != DIR_RIGHT) || r_odd);
    assign dir_next = (r_dir == DIR_BELOW) ? DIR_RIGHT : DIR_LEFT;

    // store write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = nbr.addr;
        mem_wdata = '{occ: 1'b0, wall: 1'b0, colour: r_col};
        priority case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                mem_we    = req_acc && (i_req.data.req_type == REQ_WRITE) && nbr.in_range;
                mem_wdata = '{occ: i_req.data.wr_occupied,
                              wall: i_req.data.wr_occupied & i_req.data.wr_wall,
                              colour: i_req.data.wr_colour};
            end
            S_NBR_CHK: begin
                mem_we    = !rdata.occ;
                mem_wdata = '{occ: 1'b1, wall: 1'b0, colour: r_col};
            end
            S_WR_SRC: begin
                mem_we    = 1'b1;
                mem_wdata = '{occ: 1'b0, wall: 1'b0, colour: r_col};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    fsg_cell_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (nbr.addr),
        .o_rdata (rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.idx == CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg.data.value;
            end else if (i_cfg.data.idx == CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg.data.value;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_dir       <= DIR_BELOW;
            r_out_valid <= 1'b0;
        end else begin
            // result beat taken; the final state reloads it itself
            if (o_res.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_acc) begin
                        r_req     <= i_req.data.req_type;
                        r_err     <= is_rw && !nbr.in_range;
                        r_rd_occ  <= 1'b0;
                        r_rd_wall <= 1'b0;
                        r_rd_col  <= '0;
                        r_x       <= X_W'(eff_w - CMP_W'(1));
                        r_y       <= Y_W'(eff_h - CMP_W'(1));
                        r_odd     <= 1'b1;
                        if (i_req.data.req_type == REQ_READ) begin
                            r_state <= S_RDATA;
                        end else if ((i_req.data.req_type == REQ_STEP) &&
                                     (eff_w >= CMP_W'(2)) && (eff_h >= CMP_W'(2))) begin
                            r_state <= S_HERE_RD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RDATA: begin
                    if (!r_err && rdata.occ) begin
                        r_rd_occ  <= 1'b1;
                        r_rd_wall <= rdata.wall;
                        r_rd_col  <= rdata.colour;
                    end
                    r_state <= S_FIN;
                end
                S_HERE_RD: begin
                    r_state <= S_HERE_CHK;
                end
                S_HERE_CHK: begin
                    r_col <= rdata.colour;
                    r_dir <= DIR_BELOW;
                    if (!rdata.occ || rdata.wall) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_TRY;
                    end
                end
                S_TRY: begin
                    if (try_ok) begin
                        r_state <= S_NBR_CHK;
                    end else if (r_dir == DIR_LEFT) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dir <= dir_next;
                    end
                end
                S_NBR_CHK: begin
                    if (!rdata.occ) begin
                        r_state <= S_WR_SRC;
                    end else if (r_dir == DIR_LEFT) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dir   <= dir_next;
                        r_state <= S_TRY;
                    end
                end
                S_WR_SRC: begin
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_odd <= !r_odd;
                    if (r_y == Y_W'(1)) begin
                        if (r_x == X_W'(1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_x     <= r_x - X_W'(1);
                            r_y     <= Y_W'(eff_h - CMP_W'(1));
                            r_state <= S_HERE_RD;
                        end
                    end else begin
                        r_y     <= r_y - Y_W'(1);
                        r_state <= S_HERE_RD;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out.req_echo    <= r_req;
                        r_out.rd_occupied <= r_rd_occ;
                        r_out.rd_wall     <= r_rd_wall;
                        r_out.rd_colour   <= r_rd_col;
                        r_out.coord_error <= r_err;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `FSG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, req_acc, !i_req.ready)
    `FSG_ASSERT_IMPLIES(a_scan_in_grid, i_clk, i_rst_n, r_state == S_HERE_RD, (r_x != '0) && (r_y != '0) && (CMP_W'(r_x) < eff_w) && (CMP_W'(r_y) < eff_h))
    `FSG_ASSERT_IMPLIES(a_read_fields_only_on_read, i_clk, i_rst_n, o_res.valid && (o_res.data.req_echo != REQ_READ), !o_res.data.rd_occupied && !o_res.data.rd_wall && (o_res.data.rd_colour == '0))
    `FSG_ASSERT_IMPLIES(a_err_not_with_data, i_clk, i_rst_n, o_res.valid && o_res.data.coord_error, !o_res.data.rd_occupied)

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the falling sand grid step unit: directed table, then random grids
// depends on fsg_pkg, fsg_req_if, fsg_res_if, fsg_cfg_if and falling_sand_grid_step_unit
module tb;
    import fsg_pkg::*;

    // request code with no operation behind it
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int IDLE_PCT = 17;
    localparam int RANDOM_ITEMS = 64;

    // one row of the directed table: either a grid resize or a request beat
    typedef struct {
        bit                   is_cfg;
        logic [CFG_VAL_W-1:0] width;
        logic [CFG_VAL_W-1:0] height;
        t_req                 req;
        bit                   known;
        t_res                 want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    fsg_req_if req_bus ();
    fsg_res_if res_bus ();
    fsg_cfg_if cfg_bus ();

    falling_sand_grid_step_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // grid mirror and register copies
    bit                   occ_map    [CELLS];
    bit                   wall_map   [CELLS];
    logic [COLOUR_W-1:0]  colour_map [CELLS];
    logic [CFG_VAL_W-1:0] width_reg  = GRID_WIDTH_RST;
    logic [CFG_VAL_W-1:0] height_reg = GRID_HEIGHT_RST;

    t_res      answers_due [$];
    t_stim_row directed_rows [$];
    int        bad_answers = 0;
    bit        steady_flow = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int grid_cols();
        return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int grid_rows();
        return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    // neighbours off the right or bottom edge count as occupied
    function automatic bit cell_free(input int x, input int y, input int w, input int h);
        if (x >= w || y >= h) return 1'b0;
        return !occ_map[x * MAX_HEIGHT + y];
    endfunction

    // one in-place pass, right to left, bottom to top, skipping row 0 and column 0
    function automatic void settle_sand();
        int w;
        int h;
        int visits;
        int here;
        int dest;
        w = grid_cols();
        h = grid_rows();
        visits = 0;
        if (w < 2 || h < 2) return;
        for (int x = w - 1; x > 0; x--) begin
            for (int y = h - 1; y > 0; y--) begin
                here = x * MAX_HEIGHT + y;
                visits++;
                if (!occ_map[here] || wall_map[here]) continue;
                dest = -1;
                if (cell_free(x, y + 1, w, h)) dest = here + 1;
                else if (visits[0] && cell_free(x + 1, y, w, h)) dest = here + MAX_HEIGHT;
                else if (cell_free(x - 1, y, w, h)) dest = here - MAX_HEIGHT;
                if (dest >= 0) begin
                    occ_map[dest]    = 1'b1;
                    wall_map[dest]   = 1'b0;
                    colour_map[dest] = colour_map[here];
                    occ_map[here]    = 1'b0;
                    wall_map[here]   = 1'b0;
                end
            end
        end
    endfunction

    // apply one request to the mirror and return the answer it should produce
    function automatic t_res grid_apply(input t_req r);
        t_res res;
        int   addr;
        res = '0;
        res.req_echo = r.req_type;
        if (r.req_type == REQ_STEP) begin
            settle_sand();
        end else if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
            if (int'(r.cell_x) >= grid_cols() || int'(r.cell_y) >= grid_rows()) begin
                res.coord_error = 1'b1;
            end else begin
                addr = int'(r.cell_x) * MAX_HEIGHT + int'(r.cell_y);
                if (r.req_type == REQ_WRITE) begin
                    occ_map[addr]    = r.wr_occupied;
                    wall_map[addr]   = r.wr_occupied & r.wr_wall;
                    colour_map[addr] = r.wr_colour;
                end else if (occ_map[addr]) begin
                    res.rd_occupied = 1'b1;
                    res.rd_wall     = wall_map[addr];
                    res.rd_colour   = colour_map[addr];
                end
            end
        end
        return res;
    endfunction

    function automatic t_stim_row req_row(input logic [REQ_W-1:0] kind, input int x, input int y,
                                          input bit occ, input bit wl,
                                          input logic [COLOUR_W-1:0] col,
                                          input bit known = 1'b0, input t_res want = '0);
        t_stim_row row;
        row = '{default: '0};
        row.req.req_type    = kind;
        row.req.cell_x      = COORD_W'(x);
        row.req.cell_y      = COORD_W'(y);
        row.req.wr_occupied = occ;
        row.req.wr_wall     = wl;
        row.req.wr_colour   = col;
        row.known = known;
        row.want  = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_VAL_W-1:0] w,
                                          input logic [CFG_VAL_W-1:0] h);
        t_stim_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.width  = w;
        row.height = h;
        return row;
    endfunction

    function automatic void report_answer(input string what, input t_res want, input t_res got);
        bad_answers++;
        if (bad_answers <= 10)
            $display("%0t %s: expected echo=%0d occ=%0d wall=%0d colour=%08h err=%0d, got echo=%0d occ=%0d wall=%0d colour=%08h err=%0d",
                     $realtime, what, want.req_echo, want.rd_occupied, want.rd_wall,
                     want.rd_colour, want.coord_error, got.req_echo, got.rd_occupied,
                     got.rd_wall, got.rd_colour, got.coord_error);
    endfunction

    // present one request beat, then log its answer once it is taken
    task automatic send_request(input t_req r, input bit known, input t_res want);
        t_res predicted;
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do @(posedge i_clk); while (!req_bus.ready);
        predicted = grid_apply(r);
        answers_due.push_back(known ? want : predicted);
    endtask

    // hold off the request side until every answer is back
    task automatic drain_answers();
        req_bus.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // two register beats back to back, block idle
    task automatic set_grid(input logic [CFG_VAL_W-1:0] w, input logic [CFG_VAL_W-1:0] h);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= '{idx: CFG_GRID_WIDTH, value: w};
        do @(posedge i_clk); while (!cfg_bus.ready);
        width_reg = w;
        cfg_bus.data <= '{idx: CFG_GRID_HEIGHT, value: h};
        do @(posedge i_clk); while (!cfg_bus.ready);
        height_reg = h;
        cfg_bus.valid <= 1'b0;
    endtask

    // result sink with random back-pressure
    always @(posedge i_clk) begin
        res_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each answer beat with the oldest prediction
    always @(posedge i_clk) begin : answer_check
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (answers_due.size() == 0) begin
                report_answer("answer with nothing pending", '0, res_bus.data);
            end else begin
                want = answers_due.pop_front();
                if (res_bus.data.req_echo !== want.req_echo
                        || res_bus.data.rd_occupied !== want.rd_occupied
                        || res_bus.data.rd_wall !== want.rd_wall
                        || res_bus.data.rd_colour !== want.rd_colour
                        || res_bus.data.coord_error !== want.coord_error)
                    report_answer("answer mismatch", want, res_bus.data);
            end
        end
    end

    // main sequence
    initial begin : stimulus
        t_req r;
        int   counted;
        int   phase;
        int   pick;
        int   cols;
        int   rows;
        bit   noise;
        logic [CFG_VAL_W-1:0] w;
        logic [CFG_VAL_W-1:0] h;

        i_rst_n       = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        foreach (occ_map[i]) begin
            occ_map[i]    = 1'b0;
            wall_map[i]   = 1'b0;
            colour_map[i] = '0;
        end

        // full-size grid after reset: extremes, empty writes, unknown code, edge grains
        directed_rows.push_back(req_row(REQ_READ, 0, 0, 0, 0, '0, 1, '{REQ_READ, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_WRITE, 127, 127, 1, 0, 32'hFFFF_FFFF, 1,
                                        '{REQ_WRITE, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_READ, 127, 127, 0, 0, '0, 1,
                                        '{REQ_READ, 1, 0, 32'hFFFF_FFFF, 0}));
        directed_rows.push_back(req_row(REQ_WRITE, 0, 0, 1, 1, '0, 1, '{REQ_WRITE, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_READ, 0, 0, 0, 0, '0, 1, '{REQ_READ, 1, 1, 0, 0}));
        directed_rows.push_back(req_row(REQ_WRITE, 5, 5, 0, 1, 32'hDEAD_BEEF, 1,
                                        '{REQ_WRITE, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_READ, 5, 5, 0, 0, '0, 1, '{REQ_READ, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_UNKNOWN, 127, 127, 1, 1, 32'hFFFF_FFFF, 1,
                                        '{REQ_UNKNOWN, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_WRITE, 127, 10, 1, 0, 32'h1234_5678));
        directed_rows.push_back(req_row(REQ_WRITE, 127, 126, 1, 0, 32'hA5A5_A5A5));
        directed_rows.push_back(req_row(REQ_WRITE, 64, 127, 1, 0, 32'h0F0F_0F0F));
        directed_rows.push_back(req_row(REQ_WRITE, 0, 50, 1, 0, 32'h1111_1111));
        directed_rows.push_back(req_row(REQ_WRITE, 3, 0, 1, 0, 32'h2222_2222));
        directed_rows.push_back(req_row(REQ_WRITE, 20, 20, 1, 1, 32'h3333_3333));
        directed_rows.push_back(req_row(REQ_WRITE, 20, 19, 1, 0, 32'h4444_4444));
        directed_rows.push_back(req_row(REQ_STEP, 0, 0, 0, 0, '0, 1, '{REQ_STEP, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_READ, 127, 10, 0, 0, '0));
        directed_rows.push_back(req_row(REQ_READ, 126, 126, 0, 0, '0));
        directed_rows.push_back(req_row(REQ_READ, 0, 50, 0, 0, '0));
        directed_rows.push_back(req_row(REQ_READ, 19, 20, 0, 0, '0));
        // zero width: every cell access is out of range, the pass does nothing
        directed_rows.push_back(cfg_row(8'd0, 8'd128));
        directed_rows.push_back(req_row(REQ_WRITE, 0, 0, 1, 0, 32'h5555_5555, 1,
                                        '{REQ_WRITE, 0, 0, 0, 1}));
        directed_rows.push_back(req_row(REQ_READ, 0, 0, 0, 0, '0, 1, '{REQ_READ, 0, 0, 0, 1}));
        directed_rows.push_back(req_row(REQ_STEP, 0, 0, 0, 0, '0, 1, '{REQ_STEP, 0, 0, 0, 0}));
        // oversized width saturates, one row only
        directed_rows.push_back(cfg_row(8'd255, 8'd1));
        directed_rows.push_back(req_row(REQ_STEP, 0, 0, 0, 0, '0, 1, '{REQ_STEP, 0, 0, 0, 0}));
        directed_rows.push_back(req_row(REQ_READ, 0, 1, 0, 0, '0, 1, '{REQ_READ, 0, 0, 0, 1}));
        directed_rows.push_back(req_row(REQ_READ, 3, 0, 0, 0, '0, 1,
                                        '{REQ_READ, 1, 0, 32'h2222_2222, 0}));
        // oversized height, earlier cells visible again
        directed_rows.push_back(cfg_row(8'd255, 8'd200));
        directed_rows.push_back(req_row(REQ_READ, 127, 127, 0, 0, '0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                drain_answers();
                set_grid(directed_rows[i].width, directed_rows[i].height);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].known,
                             directed_rows[i].want);
            end
        end

        // random phases, each on a freshly sized grid
        counted = 0;
        phase = 0;
        while (counted < RANDOM_ITEMS) begin
            drain_answers();
            pick = $urandom_range(9);
            unique case (pick)
                0: begin
                    w = CFG_VAL_W'($urandom_range(1));
                    h = CFG_VAL_W'($urandom_range(10));
                end
                1: begin
                    w = CFG_VAL_W'($urandom_range(255, 128));
                    h = CFG_VAL_W'($urandom_range(4, 2));
                end
                2: begin
                    w = CFG_VAL_W'($urandom_range(4, 2));
                    h = CFG_VAL_W'($urandom_range(255, 128));
                end
                default: begin
                    w = CFG_VAL_W'($urandom_range(10, 2));
                    h = CFG_VAL_W'($urandom_range(10, 2));
                end
            endcase
            set_grid(w, h);
            steady_flow <= (phase == 2);
            cols = grid_cols();
            rows = grid_rows();
            repeat ($urandom_range(16, 10)) begin
                r.cell_x      = COORD_W'($urandom);
                r.cell_y      = COORD_W'($urandom);
                r.wr_occupied = ($urandom_range(99) < 85);
                r.wr_wall     = ($urandom_range(99) < 25);
                r.wr_colour   = $urandom;
                pick  = $urandom_range(99);
                noise = (pick >= 88);
                if (pick < 45) r.req_type = REQ_WRITE;
                else if (pick < 60) r.req_type = REQ_STEP;
                else if (pick < 88) r.req_type = REQ_READ;
                else r.req_type = REQ_W'($urandom_range(3));
                // well-formed accesses land inside the grid in use
                if (!noise && cols > 0 && rows > 0) begin
                    r.cell_x = COORD_W'($urandom_range(cols - 1));
                    r.cell_y = COORD_W'($urandom_range(rows - 1));
                end
                send_request(r, 1'b0, '0);
                if (!noise) counted++;
            end
            phase++;
        end

        // wait out the last answers
        drain_answers();
        steady_flow <= 1'b0;
        repeat (20) @(posedge i_clk);
        if (bad_answers == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
